// ----- hw/rtl/sipsl_pkg.sv -----
// Shared constants and helpers for the SIP status line classifier.
// Holds the prefix table, code limits and the scan status struct.
// No dependencies.
package sipsl_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned CLASS_W = 3;

  // Byte positions: prefix is 0..7, code digits are 8..10.
  localparam logic [POS_W-1:0] PREFIX_LEN = 4'd8;
  localparam logic [POS_W-1:0] CODE_END   = 4'd11;

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [CODE_W-1:0] CODE_MIN = 10'd100;
  localparam logic [CODE_W-1:0] CODE_MAX = 10'd699;

  // Class boundaries (hundreds).
  localparam logic [CODE_W-1:0] CODE_200 = 10'd200;
  localparam logic [CODE_W-1:0] CODE_300 = 10'd300;
  localparam logic [CODE_W-1:0] CODE_400 = 10'd400;
  localparam logic [CODE_W-1:0] CODE_500 = 10'd500;
  localparam logic [CODE_W-1:0] CODE_600 = 10'd600;

  localparam logic [CLASS_W-1:0] CLASS_PROVISIONAL = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_SUCCESS     = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_REDIRECT    = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_CLIENT_ERR  = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_SERVER_ERR  = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_GLOBAL_FAIL = 3'd5;

  // 4xx codes that are never retried.
  localparam int unsigned HARD_NUM = 7;
  localparam logic [CODE_W-1:0] HARD_CODES [HARD_NUM] = '{
    10'd400, 10'd403, 10'd410, 10'd415, 10'd420, 10'd481, 10'd488
  };

  // Per-line scan status handed to the classifier.
  typedef struct packed {
    logic complete;     // all three code bytes seen
    logic prefix_bad;   // some prefix byte differed
    logic digit_bad;    // some code byte was not a digit
  } scan_t;

  // Expected character of "SIP/2.0 " at a prefix position.
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0: c = 8'h53;  // S
      3'd1: c = 8'h49;  // I
      3'd2: c = 8'h50;  // P
      3'd3: c = 8'h2f;  // /
      3'd4: c = 8'h32;  // 2
      3'd5: c = 8'h2e;  // .
      3'd6: c = 8'h30;  // 0
      3'd7: c = 8'h20;  // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sipsl_classify.sv -----
// Result classification for a finished status line.
// Turns scan status and the accumulated code into the result fields.
// Depends on sipsl_pkg.
module sipsl_classify (
  input  sipsl_pkg::scan_t                   scan,
  input  logic [sipsl_pkg::CODE_W-1:0]       code,
  output logic                               valid_res,
  output logic [sipsl_pkg::CODE_W-1:0]       status_code,
  output logic [sipsl_pkg::CLASS_W-1:0]      status_class,
  output logic                               soft_fail
);

  logic                              ok;
  logic                              hard;
  logic [sipsl_pkg::CLASS_W-1:0]     cls;

  assign ok = scan.complete && !scan.prefix_bad && !scan.digit_bad &&
              (code >= sipsl_pkg::CODE_MIN) && (code <= sipsl_pkg::CODE_MAX);

  always_comb begin
    hard = 1'b0;
    for (int i = 0; i < sipsl_pkg::HARD_NUM; i++) begin
      if (code == sipsl_pkg::HARD_CODES[i]) hard = 1'b1;
    end
  end

  always_comb begin
    priority if (code < sipsl_pkg::CODE_200) cls = sipsl_pkg::CLASS_PROVISIONAL;
    else if (code < sipsl_pkg::CODE_300) cls = sipsl_pkg::CLASS_SUCCESS;
    else if (code < sipsl_pkg::CODE_400) cls = sipsl_pkg::CLASS_REDIRECT;
    else if (code < sipsl_pkg::CODE_500) cls = sipsl_pkg::CLASS_CLIENT_ERR;
    else if (code < sipsl_pkg::CODE_600) cls = sipsl_pkg::CLASS_SERVER_ERR;
    else cls = sipsl_pkg::CLASS_GLOBAL_FAIL;
  end

  assign valid_res    = ok;
  assign status_code  = ok ? code : '0;
  assign status_class = ok ? cls : sipsl_pkg::CLASS_PROVISIONAL;
  assign soft_fail    = ok && (cls == sipsl_pkg::CLASS_CLIENT_ERR) && !hard;

endmodule

// ----- hw/rtl/sip_status_line_classifier.sv -----
// SIP status line classifier, top level.
// Input register, byte scanner state, result register; uses sipsl_classify.
// Depends on sipsl_pkg.
//
//  channel | handshake             | payload                         | beat
//  --------+-----------------------+---------------------------------+------------------
//  in      | in_valid / in_ready   | line_byte, last_byte            | one line byte
//  out     | out_valid / out_ready | valid_res, status_code,         | one result per
//          |                       | status_class, soft_fail         | line (last byte)
//
// One byte per cycle sustained while no last-byte beat waits for room in
// the result register. An accepted last byte goes to the out port through
// the input register, then the result register. rst clears the line scan
// state and both valid flags. A stalled result holds back only the next
// last-byte beat, input behind it. in_ready looks through to out_ready.
module sip_status_line_classifier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sipsl_pkg::BYTE_W-1:0]       line_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               valid_res,
  output logic [sipsl_pkg::CODE_W-1:0]       status_code,
  output logic [sipsl_pkg::CLASS_W-1:0]      status_class,
  output logic                               soft_fail
);

  // Input register
  logic                              s1_valid;
  logic [sipsl_pkg::BYTE_W-1:0]      s1_byte;
  logic                              s1_last;

  // Line scan state
  logic [sipsl_pkg::POS_W-1:0]       byte_position;
  logic                              prefix_mismatch;
  logic                              digit_error;
  logic [sipsl_pkg::CODE_W-1:0]      code_accumulator;

  logic [sipsl_pkg::POS_W-1:0]       byte_position_next;
  logic                              prefix_mismatch_next;
  logic                              digit_error_next;
  logic [sipsl_pkg::CODE_W-1:0]      code_accumulator_next;

  // Result register
  logic                              res_valid;
  logic                              res_ok;
  logic [sipsl_pkg::CODE_W-1:0]      res_code;
  logic [sipsl_pkg::CLASS_W-1:0]     res_class;
  logic                              res_soft;

  logic                              out_free;
  logic                              s1_fire;
  logic                              in_fire;
  logic                              is_digit;
  logic [3:0]                        digit;
  logic [sipsl_pkg::CODE_W-1:0]      acc_x10;
  sipsl_pkg::scan_t                  scan;
  logic                              cl_ok;
  logic [sipsl_pkg::CODE_W-1:0]      cl_code;
  logic [sipsl_pkg::CLASS_W-1:0]     cl_class;
  logic                              cl_soft;

  // A last-byte beat needs room in the result register; others never wait.
  assign out_free = !res_valid || out_ready;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= line_byte;
      s1_last <= last_byte;
    end
  end

  // Byte scan
  assign is_digit = (s1_byte >= sipsl_pkg::CHAR_ZERO) && (s1_byte <= sipsl_pkg::CHAR_NINE);
  assign digit    = s1_byte[3:0];   // low nibble of an ASCII digit is its value
  assign acc_x10  = {code_accumulator[sipsl_pkg::CODE_W-4:0], 3'b000} +
                    {code_accumulator[sipsl_pkg::CODE_W-2:0], 1'b0};

  always_comb begin
    byte_position_next    = byte_position;
    prefix_mismatch_next  = prefix_mismatch;
    digit_error_next      = digit_error;
    code_accumulator_next = code_accumulator;
    if (byte_position < sipsl_pkg::PREFIX_LEN) begin
      if (s1_byte != sipsl_pkg::prefix_char(byte_position[2:0])) begin
        prefix_mismatch_next = 1'b1;
      end
    end else if (byte_position < sipsl_pkg::CODE_END) begin
      if (is_digit) begin
        code_accumulator_next = acc_x10 + {6'd0, digit};
      end else begin
        digit_error_next = 1'b1;
      end
    end
    if (byte_position < sipsl_pkg::CODE_END) begin
      byte_position_next = byte_position + 4'd1;
    end
  end

  // Line state returns to zero after the final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      prefix_mismatch  <= 1'b0;
      digit_error      <= 1'b0;
      code_accumulator <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        byte_position    <= '0;
        prefix_mismatch  <= 1'b0;
        digit_error      <= 1'b0;
        code_accumulator <= '0;
      end else begin
        byte_position    <= byte_position_next;
        prefix_mismatch  <= prefix_mismatch_next;
        digit_error      <= digit_error_next;
        code_accumulator <= code_accumulator_next;
      end
    end
  end

  // Classify on the state as it stands after the final byte.
  assign scan.complete   = (byte_position_next >= sipsl_pkg::CODE_END);
  assign scan.prefix_bad = prefix_mismatch_next;
  assign scan.digit_bad  = digit_error_next;

  sipsl_classify u_classify (
    .scan         (scan),
    .code         (code_accumulator_next),
    .valid_res    (cl_ok),
    .status_code  (cl_code),
    .status_class (cl_class),
    .soft_fail    (cl_soft)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res_ok    <= cl_ok;
      res_code  <= cl_code;
      res_class <= cl_class;
      res_soft  <= cl_soft;
    end
  end

  assign out_valid    = res_valid;
  assign valid_res    = res_ok;
  assign status_code  = res_code;
  assign status_class = res_class;
  assign soft_fail    = res_soft;

endmodule

// ----- bench/sip_status_line_checker.sv -----
// Result checker for the SIP status line classifier bench.
// Watches both channels, predicts each line's status and compares beat by beat.
// Depends on sipsl_pkg for port widths and class codes.
`timescale 1ns / 1ps

module sip_status_line_checker
  import sipsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [BYTE_W-1:0]  line_byte,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               valid_res,
  input  logic [CODE_W-1:0]  status_code,
  input  logic [CLASS_W-1:0] status_class,
  input  logic               soft_fail,
  output int                 mismatch_count,
  output int                 pending_results
);

  typedef struct packed {
    logic               ok;
    logic [CODE_W-1:0]  code;
    logic [CLASS_W-1:0] cls;
    logic               retry;
  } line_status_t;

  localparam logic [63:0] SIP_PREFIX = "SIP/2.0 ";
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
  // 4xx codes that must not be retried
  localparam logic [CODE_W-1:0] FINAL_4XX [7] = '{
    10'd400, 10'd403, 10'd410, 10'd415, 10'd420, 10'd481, 10'd488
  };

  logic [POS_W-1:0]  scan_pos;
  logic              prefix_bad;
  logic              digit_bad;
  logic [CODE_W-1:0] code_acc;
  line_status_t      expected_status [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic logic is_final_4xx(input logic [CODE_W-1:0] code);
    foreach (FINAL_4XX[k]) if (FINAL_4XX[k] == code) return 1'b1;
    return 1'b0;
  endfunction

  task automatic track_status_byte(input logic [BYTE_W-1:0] b, input logic fin);
    line_status_t st;
    if (scan_pos < 4'd8) begin
      if (b != SIP_PREFIX[63 - 8*scan_pos -: 8]) prefix_bad = 1'b1;
    end else if (scan_pos < 4'd11) begin
      if (b >= ASCII_ZERO && b <= ASCII_NINE) code_acc = CODE_W'(code_acc * 10 + (b - ASCII_ZERO));
      else digit_bad = 1'b1;
    end
    if (scan_pos < 4'd11) scan_pos = scan_pos + 4'd1;
    if (fin) begin
      st = '0;
      if (scan_pos == 4'd11 && !prefix_bad && !digit_bad &&
          code_acc >= 10'd100 && code_acc <= 10'd699) begin
        st.ok    = 1'b1;
        st.code  = code_acc;
        st.cls   = CLASS_W'(code_acc / 100 - 1);
        st.retry = (st.cls == CLASS_CLIENT_ERR) && !is_final_4xx(code_acc);
      end
      expected_status.push_back(st);
      scan_pos   = '0;
      prefix_bad = 1'b0;
      digit_bad  = 1'b0;
      code_acc   = '0;
    end
  endtask

  always @(posedge clk) begin
    line_status_t want;
    line_status_t got;
    if (rst) begin
      scan_pos   = '0;
      prefix_bad = 1'b0;
      digit_bad  = 1'b0;
      code_acc   = '0;
      expected_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {valid_res, status_code, status_class, soft_fail};
        if (expected_status.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result beat ok=%0b code=%0d class=%0d soft=%0b",
                     $time, got.ok, got.code, got.cls, got.retry);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch exp %0b/%0d/%0d/%0b got %0b/%0d/%0d/%0b",
                       $time, want.ok, want.code, want.cls, want.retry,
                       got.ok, got.code, got.cls, got.retry);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) track_status_byte(line_byte, last_byte);
    end
    pending_results <= expected_status.size();
  end

endmodule

// ----- bench/sip_status_line_classifier_tb.sv -----
// Top of the SIP status line classifier bench: clock, reset, line stimulus, verdict.
// Result prediction and comparison live in sip_status_line_checker.
// Depends on sipsl_pkg and the classifier RTL.
`timescale 1ns / 1ps

module sip_status_line_classifier_tb;
  import sipsl_pkg::*;

  localparam logic [63:0]       SIP_PREFIX = "SIP/2.0 ";
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CR         = 8'h0d;
  localparam logic [BYTE_W-1:0] LF         = 8'h0a;
  localparam int TARGET_BYTES = 1600;
  // past this many bytes both sides run flat out to the end
  localparam int CALM_AFTER   = 1400;

  // Codes worth hitting often: class edges, hard 4xx codes, a few soft
  // 4xx, and values outside the legal range.
  localparam int unsigned NOTABLE_CODES [24] = '{
    100, 199, 200, 299, 300, 399, 400, 403, 410, 415, 420, 481,
    488, 401, 486, 499, 500, 599, 600, 699, 0, 99, 700, 999
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  line_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic               valid_res;
  logic [CODE_W-1:0]  status_code;
  logic [CLASS_W-1:0] status_class;
  logic               soft_fail;

  int                 mismatch_count;
  int                 pending_results;
  int                 sent_bytes;
  int                 gap_pct;     // chance of a sender gap before each beat
  bit                 calm;        // no idling on either side once set
  logic [BYTE_W-1:0]  line_q [$];  // bytes of the line being built

  always #6 clk = ~clk;

  sip_status_line_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .line_byte    (line_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .status_code  (status_code),
    .status_class (status_class),
    .soft_fail    (soft_fail)
  );

  sip_status_line_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .line_byte       (line_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .valid_res       (valid_res),
    .status_code     (status_code),
    .status_class    (status_class),
    .soft_fail       (soft_fail),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // One byte beat. An optional gap drops valid first; once valid goes up it
  // stays up with the same payload until the accepting edge.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fin);
    if (!calm && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Sends the built line, last flag on its final byte.
  task automatic send_line();
    foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic push_prefix();
    for (int k = 0; k < 8; k++) line_q.push_back(SIP_PREFIX[63 - 8*k -: 8]);
  endtask

  // Three decimal digits, leading zeros kept.
  task automatic push_code(input int unsigned code);
    line_q.push_back(ASCII_ZERO + BYTE_W'((code / 100) % 10));
    line_q.push_back(ASCII_ZERO + BYTE_W'((code / 10) % 10));
    line_q.push_back(ASCII_ZERO + BYTE_W'(code % 10));
  endtask

  // Mostly legal codes, a share of notable ones, some anywhere in 000..999.
  function automatic int unsigned pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return NOTABLE_CODES[$urandom_range(0, 23)];
    if (roll == 3) return $urandom_range(0, 999);
    return $urandom_range(100, 699);
  endfunction

  // Builds one random line into line_q. Most lines are well formed so the
  // code digits and the classifier get exercised; the rest break the prefix,
  // put a non-digit in the code, end early, or are plain noise.
  task automatic make_line();
    int unsigned       kind;
    int unsigned       n;
    logic [BYTE_W-1:0] junk;
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      push_prefix();
      push_code(pick_code());
    end
    if (kind >= 60 && kind < 70) begin
      // corrupt one prefix byte (may land on the right char, that's fine)
      line_q[$urandom_range(0, 7)] = BYTE_W'($urandom_range(0, 255));
    end else if (kind >= 70 && kind < 80) begin
      // non-digit in the code: the chars either side of '0'..'9' or anything
      case ($urandom_range(0, 2))
        0: junk = 8'h2f;
        1: junk = 8'h3a;
        default: begin
          do junk = BYTE_W'($urandom_range(0, 255));
          while (junk >= 8'h30 && junk <= 8'h39);
        end
      endcase
      line_q[8 + $urandom_range(0, 2)] = junk;
    end else if (kind >= 80 && kind < 90) begin
      // short line: final byte lands before the third code digit
      n = $urandom_range(1, 10);
      while (line_q.size() > n) void'(line_q.pop_back());
    end else if (kind >= 90) begin
      n = $urandom_range(1, 20);
      repeat (n) line_q.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    // trailing bytes after the code are ignored by the block
    if (kind < 80) begin
      n = $urandom_range(0, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: line_q.push_back(CR);
          1: line_q.push_back(LF);
          2: line_q.push_back(8'h20);
          default: line_q.push_back(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Result side: random stall bursts, some long ready stretches,
  // always ready once the run has gone calm.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    line_byte  <= '0;
    last_byte  <= 1'b0;
    sent_bytes = 0;
    gap_pct    = 0;
    calm       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte lines at both byte extremes, the top legal code
    // with CR LF trailer, and a line cut short after the first code digit.
    line_q = '{8'hff};
    send_line();
    line_q = '{8'h00};
    send_line();
    push_prefix();
    push_code(699);
    line_q.push_back(CR);
    line_q.push_back(LF);
    send_line();
    push_prefix();
    line_q.push_back(ASCII_ZERO + 8'd1);
    send_line();

    // Random lines; sender gap rate changes per line so there are both
    // gappy and back-to-back stretches.
    while (sent_bytes < TARGET_BYTES) begin
      calm = (sent_bytes >= CALM_AFTER);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 5;
        default: gap_pct = 30;
      endcase
      make_line();
      send_line();
    end
    in_valid <= 1'b0;

    // Drain: pending count is registered in the checker, so step once first.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sip_status_line_classifier.f -----
hw/rtl/sipsl_pkg.sv
hw/rtl/sipsl_classify.sv
hw/rtl/sip_status_line_classifier.sv
bench/sip_status_line_checker.sv
bench/sip_status_line_classifier_tb.sv
